>>> hw/rtl/lkwf_pkg.sv
// Shared types and constants for the windowed optical flow core.
`timescale 1ns / 1ps
package lkwf_pkg;

    localparam int PIX_W   = 8;
    localparam int MOTION_W = 7;
    localparam int FLOW_W  = 16;
    localparam int ACC_W   = 32;
    localparam int PROD_W  = 2 * ACC_W;
    localparam int FRAC_W  = 8;
    // Quotient bits below the saturation point: 7 integer plus 8 fraction.
    localparam int QUO_W   = 15;
    localparam int APB_AW  = 3;

    localparam logic APB_IDX_MOTION_LOW  = 1'b0;
    localparam logic APB_IDX_MOTION_HIGH = 1'b1;

    localparam logic [MOTION_W-1:0] MOTION_LOW_RST  = 7'd1;
    localparam logic [MOTION_W-1:0] MOTION_HIGH_RST = 7'd20;

    typedef struct packed {
        logic [PIX_W-1:0] center_pixel;
        logic [PIX_W-1:0] up_pixel;
        logic [PIX_W-1:0] left_pixel;
        logic [PIX_W-1:0] next_pixel;
        logic             last_in_window;
    } t_in_item;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow_u;
        logic signed [FLOW_W-1:0] flow_v;
        logic                     singular;
        logic                     significant;
    } t_result;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum_xx;
        logic signed [ACC_W-1:0] sum_xy;
        logic signed [ACC_W-1:0] sum_yy;
        logic signed [ACC_W-1:0] sum_xt;
        logic signed [ACC_W-1:0] sum_yt;
    } t_sums;

endpackage

>>> hw/rtl/lkwf_front.sv
// Front end: gradient products and saturating window sums.
`timescale 1ns / 1ps
module lkwf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lkwf_pkg::t_in_item i_item,
    output logic              o_push,
    output lkwf_pkg::t_sums   o_sums
);
    import lkwf_pkg::*;

    localparam logic signed [ACC_W:0] ACC_POS = 33'sd2147483647;
    localparam logic signed [ACC_W:0] ACC_NEG = -33'sd2147483647;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [17:0]      b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W-17){b[17]}}, b};
        if (s > ACC_POS) begin
            s = ACC_POS;
        end else if (s < ACC_NEG) begin
            s = ACC_NEG;
        end
        return s[ACC_W-1:0];
    endfunction

    t_sums r_acc;
    t_sums n_acc;
    logic signed [8:0] w_ix, w_iy, w_it;

    always_comb begin
        w_ix = $signed({1'b0, i_item.center_pixel}) - $signed({1'b0, i_item.left_pixel});
        w_iy = $signed({1'b0, i_item.center_pixel}) - $signed({1'b0, i_item.up_pixel});
        w_it = $signed({1'b0, i_item.center_pixel}) - $signed({1'b0, i_item.next_pixel});
        n_acc.sum_xx = sat_add(r_acc.sum_xx, w_ix * w_ix);
        n_acc.sum_xy = sat_add(r_acc.sum_xy, w_ix * w_iy);
        n_acc.sum_yy = sat_add(r_acc.sum_yy, w_iy * w_iy);
        n_acc.sum_xt = sat_add(r_acc.sum_xt, w_ix * w_it);
        n_acc.sum_yt = sat_add(r_acc.sum_yt, w_iy * w_it);
    end

    assign o_push = i_accept && i_item.last_in_window;
    assign o_sums = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept) begin
            r_acc <= i_item.last_in_window ? '0 : n_acc;
        end
    end

endmodule

>>> hw/rtl/lkwf_queue.sv
// Short queue of finished window sums between the front end and the solver.
`timescale 1ns / 1ps
module lkwf_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lkwf_pkg::t_sums i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lkwf_pkg::t_sums o_data
);
    import lkwf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_sums         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT) else $error("queue count out of range");

endmodule

>>> hw/rtl/lkwf_solver.sv
// Back end: 2x2 solve with a shared multiplier and a serial divider.
`timescale 1ns / 1ps
module lkwf_solver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  lkwf_pkg::t_sums               i_q_data,
    output logic                          o_q_pop,
    input  logic [lkwf_pkg::MOTION_W-1:0] i_motion_low,
    input  logic [lkwf_pkg::MOTION_W-1:0] i_motion_high,
    input  logic                          i_pop,
    output logic                          o_empty,
    output lkwf_pkg::t_result             o_result
);
    import lkwf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIFF, S_DIV_SETUP, S_DIV, S_ROUND, S_DONE
    } t_state;

    localparam logic [2:0] LAST_MUL = 3'd5;
    localparam logic [3:0] LAST_STEP = 4'(QUO_W - 1);
    localparam int REM_W = PROD_W + FRAC_W;
    localparam int DIV_W = PROD_W + QUO_W - 1;

    t_state                    r_state;
    t_sums                     r_s;
    logic [2:0]                r_mcnt;
    logic signed [PROD_W-1:0]  r_p [6];
    logic signed [PROD_W-1:0]  r_det, r_nu, r_nv;
    logic                      r_sel;
    logic                      r_neg, r_sat;
    logic [PROD_W-1:0]         r_ud;
    logic [REM_W-1:0]          r_rem;
    logic [DIV_W-1:0]          r_div;
    logic [QUO_W-1:0]          r_quo;
    logic [3:0]                r_step;
    logic signed [FLOW_W-1:0]  r_u, r_v;
    logic                      r_sing;
    logic                      r_out_valid;
    t_result                   r_out;

    logic signed [ACC_W-1:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0]  w_num;
    logic [PROD_W-1:0]         w_un, w_ud;
    logic                      w_ge;
    logic [REM_W-1:0]          w_rem_next;
    logic [FLOW_W:0]           w_mag;
    logic signed [FLOW_W-1:0]  w_flow;
    logic signed [FLOW_W:0]    w_lo, w_hi;
    logic                      w_sig;

    always_comb begin
        unique case (r_mcnt)
            3'd0:    begin w_ma = r_s.sum_xx; w_mb = r_s.sum_yy; end
            3'd1:    begin w_ma = r_s.sum_xy; w_mb = r_s.sum_xy; end
            3'd2:    begin w_ma = r_s.sum_yy; w_mb = r_s.sum_xt; end
            3'd3:    begin w_ma = r_s.sum_xy; w_mb = r_s.sum_yt; end
            3'd4:    begin w_ma = r_s.sum_xx; w_mb = r_s.sum_yt; end
            default: begin w_ma = r_s.sum_xy; w_mb = r_s.sum_xt; end
        endcase
    end

    always_comb begin
        w_num = r_sel ? r_nv : r_nu;
        w_un  = w_num[PROD_W-1] ? PROD_W'(-w_num) : PROD_W'(w_num);
        w_ud  = r_det[PROD_W-1] ? PROD_W'(-r_det) : PROD_W'(r_det);
        w_ge  = {{(DIV_W-REM_W){1'b0}}, r_rem} >= r_div;
        w_rem_next = w_ge ? REM_W'({{(DIV_W-REM_W){1'b0}}, r_rem} - r_div) : r_rem;
        // Round half away from zero on the remaining remainder.
        w_mag = {2'b00, r_quo}
              + {{FLOW_W{1'b0}}, ({r_rem, 1'b0} >= {{(REM_W-PROD_W+1){1'b0}}, r_ud})};
        if (r_neg) begin
            w_flow = (r_sat || w_mag >= 17'd32768) ? -16'sd32768 : FLOW_W'(-w_mag);
        end else begin
            w_flow = (r_sat || w_mag > 17'd32767) ? 16'sd32767 : FLOW_W'(w_mag);
        end
        w_lo  = $signed({2'b00, i_motion_low,  8'h00});
        w_hi  = $signed({2'b00, i_motion_high, 8'h00});
        w_sig = ($signed({r_u[FLOW_W-1], r_u}) > w_lo && $signed({r_u[FLOW_W-1], r_u}) < w_hi)
             || ($signed({r_v[FLOW_W-1], r_v}) > w_lo && $signed({r_v[FLOW_W-1], r_v}) < w_hi);
    end

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_s     <= i_q_data;
                        r_mcnt  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p[r_mcnt] <= w_ma * w_mb;
                    r_mcnt      <= r_mcnt + 1'b1;
                    if (r_mcnt == LAST_MUL) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_det  <= r_p[0] - r_p[1];
                    r_nu   <= r_p[2] - r_p[3];
                    r_nv   <= r_p[4] - r_p[5];
                    r_sing <= (r_p[0] == r_p[1]);
                    r_sel  <= 1'b0;
                    r_u    <= '0;
                    r_v    <= '0;
                    r_state <= (r_p[0] == r_p[1]) ? S_DONE : S_DIV_SETUP;
                end
                S_DIV_SETUP: begin
                    r_neg  <= w_num[PROD_W-1] != r_det[PROD_W-1];
                    r_ud   <= w_ud;
                    // An integer part of 128 or more saturates either way.
                    r_sat  <= {7'b0, w_un} >= {w_ud, 7'b0};
                    r_rem  <= {w_un, {FRAC_W{1'b0}}};
                    r_div  <= {w_ud, {(QUO_W-1){1'b0}}};
                    r_quo  <= '0;
                    r_step <= LAST_STEP;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_rem_next;
                    r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                    r_div  <= r_div >> 1;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_sel) begin
                        r_v     <= w_flow;
                        r_state <= S_DONE;
                    end else begin
                        r_u     <= w_flow;
                        r_sel   <= 1'b1;
                        r_state <= S_DIV_SETUP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_pop) begin
                        r_out.flow_u      <= r_u;
                        r_out.flow_v      <= r_v;
                        r_out.singular    <= r_sing;
                        r_out.significant <= w_sig;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.singular) |-> (r_out.flow_u == '0 && r_out.flow_v == '0))
        else $error("singular result with nonzero flow");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or changed");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_MUL))
        else $error("window taken without starting the solve");

endmodule

>>> hw/rtl/lucas_kanade_window_flow_core.sv
// Top level of the windowed optical flow core: register port and block wiring.
`timescale 1ns / 1ps
// The core takes one window pixel per request and updates five saturating gradient sums in
// that cycle, so pixels stream in at one per clock while full is low. The request marked last
// in window hands the sums to a queue of QUEUE_DEPTH windows and clears them; the solver takes
// one window at a time from the queue, forms six products on its one 32x32 multiplier, takes
// the differences, runs two 15-step serial divisions with setup and rounding and posts the
// result, skipping the divisions when the determinant is zero. Windows that come faster are
// paced by the solver: push sees full while the queue holds QUEUE_DEPTH unsolved windows. Each
// window yields one result, held on the result ports until popped.
module lucas_kanade_window_flow_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  lkwf_pkg::t_in_item            i_item,
    output logic                          empty,
    input  logic                          pop,
    output lkwf_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkwf_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lkwf_pkg::*;

    logic [MOTION_W-1:0] r_motion_low, r_motion_high;
    logic                w_accept, w_push, w_q_full, w_q_valid, w_q_pop;
    t_sums               w_sums, w_q_data;

    assign pready   = 1'b1;
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    always_comb begin
        unique case (paddr[2])
            APB_IDX_MOTION_LOW:  prdata = {25'b0, r_motion_low};
            APB_IDX_MOTION_HIGH: prdata = {25'b0, r_motion_high};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_low  <= MOTION_LOW_RST;
            r_motion_high <= MOTION_HIGH_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                APB_IDX_MOTION_LOW:  r_motion_low  <= pwdata[MOTION_W-1:0];
                APB_IDX_MOTION_HIGH: r_motion_high <= pwdata[MOTION_W-1:0];
                default: ;
            endcase
        end
    end

    lkwf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_push),
        .o_sums   (w_sums)
    );

    lkwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_sums),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    lkwf_solver u_solver (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_q_pop       (w_q_pop),
        .i_motion_low  (r_motion_low),
        .i_motion_high (r_motion_high),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result      (o_result)
    );

endmodule
